FILE: rtl/ida_pkg.sv
// Shared types, codes and sizes of the ID allocator table.
`timescale 1ns / 1ps

package ida_pkg;

	localparam int NUM_SLOTS  = 256;
	localparam int VALUE_BITS = 32;
	localparam int SLOT_W     = $clog2(NUM_SLOTS);

	localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_FIND   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_NOSPACE  = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [1:0]            op;
		logic [1:0]            status;    // early verdict; ST_OK means go on
		logic [SLOT_W-1:0]     lo;        // allocation window, in slots
		logic [SLOT_W-1:0]     hi;
		logic                  win_empty;
		logic [SLOT_W-1:0]     slot;      // lookup slot for remove and find
		logic                  slot_ok;   // lookup lies inside the table
		logic [VALUE_BITS-1:0] value;
	} req_t;

endpackage

FILE: rtl/id_allocator_table_unit.sv
// Top level of the ID allocator table: request stage, slot bitmap, value store.
`timescale 1ns / 1ps

// Usage
//   Request channel (in_valid / in_stall): op, start_id, end_id, lookup_id,
//   value_in. Allocate takes the lowest free slot whose ID lies in [start_id,
//   end_id-1], or up to INT_MAX when end_id is 0 or negative, and stores
//   value_in; remove frees an ID and returns its value; find returns it only.
//   Result channel (out_valid / out_stall): status, granted_id, value_out,
//   exactly one result per request, in request order.
//   Config channel (cfg_valid / cfg_ready): cfg_data sets id_base, the ID of
//   slot zero. Write it only while no request is in flight.
//   A request is registered in the request stage, then its result in the
//   result register. One request is taken every cycle while in_stall is low:
//   the slot bitmap is updated at the end of the request stage, and a value
//   read of the slot written that same cycle is bypassed from the write port.
//   Reset clears the bitmap (all IDs free), id_base and both stages at once;
//   no clearing pass is needed. When the receiver stalls, the result register
//   holds, then the request stage fills, then in_stall rises.

module id_allocator_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] start_id,
	input  logic [31:0] end_id,
	input  logic [31:0] lookup_id,
	input  logic [31:0] value_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] granted_id,
	output logic [31:0] value_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic [31:0]                      id_base_q;
	logic [ida_pkg::NUM_SLOTS-1:0]    used_q;
	logic [ida_pkg::VALUE_BITS-1:0]   value_mem_q [ida_pkg::NUM_SLOTS];

	ida_pkg::req_t                    dec_req;
	ida_pkg::req_t                    req_s1;
	logic                             valid_s1;
	logic [ida_pkg::VALUE_BITS-1:0]   rdata_s1;

	logic                             res_valid_q;
	logic [1:0]                       status_q;
	logic [31:0]                      granted_q;
	logic [31:0]                      value_q;

	logic                             adv;
	logic                             in_acc;
	logic                             found;
	logic [ida_pkg::SLOT_W-1:0]       free_idx;
	logic                             look_hit;
	logic                             alloc_ok;
	logic                             rem_hit;
	logic                             wr_en;
	logic [1:0]                       res_status;
	logic [31:0]                      res_granted;
	logic [31:0]                      res_value;

	assign cfg_ready = 1'b1;
	assign adv       = !res_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !adv;
	assign in_acc    = in_valid && !in_stall;

	ida_req_decode u_decode (
		.op       (op),
		.start_id (start_id),
		.end_id   (end_id),
		.lookup_id(lookup_id),
		.value_in (value_in),
		.id_base  (id_base_q),
		.req      (dec_req)
	);

	ida_free_search u_search (
		.used     (used_q),
		.lo       (req_s1.lo),
		.hi       (req_s1.hi),
		.win_empty(req_s1.win_empty),
		.found    (found),
		.idx      (free_idx)
	);

	always_comb begin
		look_hit    = req_s1.slot_ok && used_q[req_s1.slot];
		alloc_ok    = valid_s1 && (req_s1.op == ida_pkg::OP_ALLOC) &&
			(req_s1.status == ida_pkg::ST_OK) && found;
		rem_hit     = valid_s1 && (req_s1.op == ida_pkg::OP_REMOVE) && look_hit;
		wr_en       = adv && alloc_ok;

		res_status  = req_s1.status;
		res_granted = 32'd0;
		res_value   = 32'd0;
		unique case (req_s1.op) inside
			ida_pkg::OP_ALLOC: begin
				if (req_s1.status == ida_pkg::ST_OK) begin
					if (found) begin
						res_status  = ida_pkg::ST_OK;
						res_granted = id_base_q + 32'(free_idx);
					end else begin
						res_status  = ida_pkg::ST_NOSPACE;
					end
				end
			end
			ida_pkg::OP_REMOVE, ida_pkg::OP_FIND: begin
				if (look_hit) begin
					res_status = ida_pkg::ST_OK;
					res_value  = 32'(rdata_s1);
				end else begin
					res_status = ida_pkg::ST_NOTFOUND;
				end
			end
			default: begin
				res_status = ida_pkg::ST_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			id_base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (adv) begin
			if (alloc_ok)
				used_q[free_idx] <= 1'b1;
			if (rem_hit)
				used_q[req_s1.slot] <= 1'b0;
		end
	end

	// value store: one write port, one registered read port with write bypass
	always_ff @(posedge clk) begin
		if (wr_en)
			value_mem_q[free_idx] <= req_s1.value;
		if (in_acc) begin
			if (wr_en && free_idx == dec_req.slot)
				rdata_s1 <= req_s1.value;
			else
				rdata_s1 <= value_mem_q[dec_req.slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			req_s1 <= dec_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	// hold the result while the receiver stalls
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			status_q  <= res_status;
			granted_q <= res_granted;
			value_q   <= res_value;
		end
	end

	assign out_valid  = res_valid_q;
	assign status     = status_q;
	assign granted_id = granted_q;
	assign value_out  = value_q;

`ifndef SYNTHESIS
	a_alloc_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_ok |-> !used_q[free_idx])
		else $error("allocation picked an occupied slot");

	a_alloc_marks_used: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && alloc_ok) |=> used_q[$past(free_idx)])
		else $error("allocated slot not marked used");

	a_remove_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && rem_hit) |=> !used_q[$past(req_s1.slot)])
		else $error("removed slot still marked used");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && res_valid_q))
		else $error("request stalled with a free stage");
`endif

endmodule

FILE: rtl/ida_req_decode.sv
// Request decode: turns a raw transaction into slot window or lookup slot.
`timescale 1ns / 1ps

module ida_req_decode (
	input  logic [1:0]   op,
	input  logic [31:0]  start_id,
	input  logic [31:0]  end_id,
	input  logic [31:0]  lookup_id,
	input  logic [31:0]  value_in,
	input  logic [31:0]  id_base,
	output ida_pkg::req_t req
);

	logic [31:0] limit;
	logic [31:0] lo_off;
	logic [31:0] hi_off;
	logic [31:0] look_off;

	always_comb begin
		limit    = (end_id != 32'd0 && !end_id[31]) ? end_id - 32'd1 : ida_pkg::INT_MAX;
		lo_off   = (start_id < id_base) ? 32'd0 : start_id - id_base;
		hi_off   = limit - id_base;
		look_off = lookup_id - id_base;

		req.op        = op;
		req.status    = ida_pkg::ST_OK;
		req.lo        = lo_off[ida_pkg::SLOT_W-1:0];
		req.win_empty = (lo_off >= 32'(ida_pkg::NUM_SLOTS));
		req.hi        = (hi_off > 32'(ida_pkg::NUM_SLOTS - 1)) ?
			ida_pkg::SLOT_W'(ida_pkg::NUM_SLOTS - 1) : hi_off[ida_pkg::SLOT_W-1:0];
		req.slot      = look_off[ida_pkg::SLOT_W-1:0];
		req.slot_ok   = (lookup_id >= id_base) && (look_off < 32'(ida_pkg::NUM_SLOTS));
		req.value     = ida_pkg::VALUE_BITS'(value_in);

		unique case (op)
			ida_pkg::OP_ALLOC: begin
				if (start_id[31])
					req.status = ida_pkg::ST_INVALID;
				else if (limit < id_base || start_id > limit)
					req.status = ida_pkg::ST_NOSPACE;
			end
			ida_pkg::OP_REMOVE, ida_pkg::OP_FIND: begin
				req.status = ida_pkg::ST_OK;
			end
			default: begin
				req.status = ida_pkg::ST_INVALID;
			end
		endcase
	end

endmodule

FILE: rtl/ida_free_search.sv
// Free slot search: lowest free slot inside a window, two-level priority tree.
`timescale 1ns / 1ps

module ida_free_search (
	input  logic [ida_pkg::NUM_SLOTS-1:0] used,
	input  logic [ida_pkg::SLOT_W-1:0]    lo,
	input  logic [ida_pkg::SLOT_W-1:0]    hi,
	input  logic                          win_empty,
	output logic                          found,
	output logic [ida_pkg::SLOT_W-1:0]    idx
);

	localparam int GRP_W   = 16;
	localparam int LIDX_W  = $clog2(GRP_W);
	localparam int NUM_GRP = (ida_pkg::NUM_SLOTS + GRP_W - 1) / GRP_W;
	localparam int GIDX_W  = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
	localparam int PAD_W   = NUM_GRP * GRP_W;

	logic [ida_pkg::NUM_SLOTS-1:0] cand;
	logic [PAD_W-1:0]              padded;
	logic [GRP_W-1:0]              grp;
	logic [GRP_W-1:0]              grp_oh;
	logic [LIDX_W-1:0]             lidx [NUM_GRP];
	logic [NUM_GRP-1:0]            grp_any;
	logic [NUM_GRP-1:0]            first_grp;
	logic [GIDX_W-1:0]             gidx;
	logic [LIDX_W-1:0]             sel_lidx;

	always_comb begin
		for (int i = 0; i < ida_pkg::NUM_SLOTS; i++) begin
			cand[i] = !used[i] && !win_empty &&
				(ida_pkg::SLOT_W'(i) >= lo) && (ida_pkg::SLOT_W'(i) <= hi);
		end
		padded = PAD_W'(cand);

		// isolate the lowest set bit of each group, then encode it
		for (int g = 0; g < NUM_GRP; g++) begin
			grp        = padded[g*GRP_W +: GRP_W];
			grp_any[g] = |grp;
			grp_oh     = grp & (~grp + GRP_W'(1));
			lidx[g]    = '0;
			for (int b = 0; b < GRP_W; b++) begin
				if (grp_oh[b])
					lidx[g] = lidx[g] | LIDX_W'(b);
			end
		end

		first_grp = grp_any & (~grp_any + NUM_GRP'(1));
		gidx      = '0;
		sel_lidx  = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			if (first_grp[g]) begin
				gidx     = gidx | GIDX_W'(g);
				sel_lidx = sel_lidx | lidx[g];
			end
		end

		found = |grp_any;
		idx   = ida_pkg::SLOT_W'({gidx, sel_lidx});
	end

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the ID allocator table unit.
`timescale 1ns / 1ps

module tb_top;
	import ida_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         QUIET_LIMIT = 2000;
	localparam int         PHASE_ITEMS = 190;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] start_id;
		logic [31:0] end_id;
		logic [31:0] lookup_id;
		logic [31:0] value_in;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] granted_id;
		logic [31:0] value_out;
	} result_t;

	typedef struct packed {
		request_t rq;
		bit       typed;
		result_t  res;
	} vector_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [31:0] start_id;
	logic [31:0] end_id;
	logic [31:0] lookup_id;
	logic [31:0] value_in;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] granted_id;
	logic [31:0] value_out;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	// Mirror of the table
	logic [31:0] base_model = '0;
	bit          slot_taken [NUM_SLOTS];
	logic [31:0] slot_data [NUM_SLOTS];

	result_t pending_results[$];
	int      mismatch_count = 0;
	int      quiet_cycles = 0;
	bit      burst = 1'b0;
	bit      long_hold = 1'b0;

	// Directed rows: typed results where obvious, the rest go through the predictor
	vector_t directed_rows[$] = '{
		'{'{OP_FIND,   32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, '{ST_NOTFOUND, 32'd0, 32'd0}},
		'{'{OP_REMOVE, 32'd0, 32'd0, 32'd5, 32'd0}, 1'b1, '{ST_NOTFOUND, 32'd0, 32'd0}},
		'{'{OP_ALLOC, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1}, 1'b1, '{ST_INVALID, 32'd0, 32'd0}},
		'{'{OP_ALLOC, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1}, 1'b1,
			'{ST_INVALID, 32'd0, 32'd0}},
		'{'{OP_ALLOC, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF}, 1'b1, '{ST_OK, 32'd0, 32'd0}},
		'{'{OP_ALLOC, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0}, 1'b1, '{ST_OK, 32'd1, 32'd0}},
		'{'{OP_ALLOC, 32'd0, 32'h8000_0000, 32'd0, 32'h1234_5678}, 1'b1,
			'{ST_OK, 32'd2, 32'd0}},
		'{'{OP_ALLOC, 32'd10, 32'd11, 32'd0, 32'h0BAD_F00D}, 1'b1, '{ST_OK, 32'd10, 32'd0}},
		'{'{OP_ALLOC, 32'd10, 32'd11, 32'd0, 32'd7}, 1'b1, '{ST_NOSPACE, 32'd0, 32'd0}},
		'{'{OP_ALLOC, 32'd20, 32'd20, 32'd0, 32'd7}, 1'b1, '{ST_NOSPACE, 32'd0, 32'd0}},
		'{'{OP_ALLOC, 32'd0, 32'd1, 32'd0, 32'd7}, 1'b1, '{ST_NOSPACE, 32'd0, 32'd0}},
		'{'{OP_ALLOC, 32'd300, 32'd0, 32'd0, 32'd7}, 1'b1, '{ST_NOSPACE, 32'd0, 32'd0}},
		'{'{OP_ALLOC, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd7}, 1'b1,
			'{ST_NOSPACE, 32'd0, 32'd0}},
		'{'{OP_ALLOC, 32'd255, 32'h7FFF_FFFF, 32'd0, 32'hA5A5_A5A5}, 1'b1,
			'{ST_OK, 32'd255, 32'd0}},
		'{'{OP_FIND, 32'd0, 32'd0, 32'd255, 32'd0}, 1'b1, '{ST_OK, 32'd0, 32'hA5A5_A5A5}},
		'{'{OP_FIND, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, '{ST_OK, 32'd0, 32'hFFFF_FFFF}},
		'{'{OP_FIND, 32'd0, 32'd0, 32'd256, 32'd0}, 1'b1, '{ST_NOTFOUND, 32'd0, 32'd0}},
		'{'{OP_FIND, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0}, 1'b1,
			'{ST_NOTFOUND, 32'd0, 32'd0}},
		'{'{OP_REMOVE, 32'd0, 32'd0, 32'd1, 32'd0}, 1'b1, '{ST_OK, 32'd0, 32'd0}},
		'{'{OP_FIND, 32'd0, 32'd0, 32'd1, 32'd0}, 1'b1, '{ST_NOTFOUND, 32'd0, 32'd0}},
		'{'{OP_ALLOC, 32'd0, 32'd0, 32'd0, 32'd5}, 1'b1, '{ST_OK, 32'd1, 32'd0}},
		'{'{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
			'{ST_INVALID, 32'd0, 32'd0}},
		'{'{OP_REMOVE, 32'd0, 32'd0, 32'd2, 32'd0}, 1'b1, '{ST_OK, 32'd0, 32'h1234_5678}},
		'{'{OP_ALLOC, 32'd3, 32'd0, 32'd0, 32'h5A5A_5A5A}, 1'b0, '0},
		'{'{OP_FIND, 32'd0, 32'd0, 32'd10, 32'd0}, 1'b0, '0}
	};

	id_allocator_table_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.start_id   (start_id),
		.end_id     (end_id),
		.lookup_id  (lookup_id),
		.value_in   (value_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.granted_id (granted_id),
		.value_out  (value_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one request to the mirror and return the result it must produce
	function automatic result_t id_table_apply(request_t rq);
		result_t     r;
		logic [31:0] limit;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] off;
		longint      s;
		bit          found;
		r = '0;
		found = 1'b0;
		if (rq.op == OP_ALLOC) begin
			if (rq.start_id[31]) begin
				r.status = ST_INVALID;
			end else begin
				limit = (rq.end_id != 0 && !rq.end_id[31]) ? rq.end_id - 32'd1 : INT_MAX;
				if (limit < base_model || rq.start_id > limit) begin
					r.status = ST_NOSPACE;
				end else begin
					lo = (rq.start_id < base_model) ? 32'd0 : rq.start_id - base_model;
					hi = limit - base_model;
					if (hi > NUM_SLOTS - 1)
						hi = NUM_SLOTS - 1;
					for (s = lo; s <= hi; s++) begin
						if (!slot_taken[s]) begin
							found = 1'b1;
							break;
						end
					end
					if (found) begin
						slot_taken[s] = 1'b1;
						slot_data[s] = rq.value_in;
						r.granted_id = base_model + s[31:0];
					end else begin
						r.status = ST_NOSPACE;
					end
				end
			end
		end else if (rq.op == OP_REMOVE || rq.op == OP_FIND) begin
			off = rq.lookup_id - base_model;
			if (rq.lookup_id >= base_model && off < NUM_SLOTS && slot_taken[off]) begin
				r.value_out = slot_data[off];
				if (rq.op == OP_REMOVE)
					slot_taken[off] = 1'b0;
			end else begin
				r.status = ST_NOTFOUND;
			end
		end else begin
			r.status = ST_INVALID;
		end
		return r;
	endfunction

	// Mostly windows and lookups near the base, some noise and bad arguments
	function automatic request_t random_request();
		request_t rq;
		int       pick;
		rq.start_id = $urandom();
		rq.end_id = $urandom();
		rq.lookup_id = $urandom();
		rq.value_in = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			rq.op = OP_ALLOC;
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				if (base_model <= INT_MAX - 300)
					rq.start_id = base_model + $urandom_range(0, 270);
				else
					rq.start_id = INT_MAX - $urandom_range(0, 300);
			end else if (pick == 7) begin
				if (base_model <= INT_MAX)
					rq.start_id = $urandom_range(0, base_model);
				else
					rq.start_id = $urandom() & INT_MAX;
			end else if (pick == 8) begin
				rq.start_id = $urandom() | 32'h8000_0000;
			end
			pick = $urandom_range(0, 9);
			if (pick < 3)
				rq.end_id = '0;
			else if (pick == 3)
				rq.end_id = $urandom() | 32'h8000_0000;
			else if (pick < 9)
				rq.end_id = rq.start_id + $urandom_range(1, 40);
		end else if (pick < 95) begin
			rq.op = (pick < 70) ? OP_REMOVE : OP_FIND;
			pick = $urandom_range(0, 9);
			if (pick < 8)
				rq.lookup_id = base_model + $urandom_range(0, 259);
			else if (pick == 8)
				rq.lookup_id = base_model - $urandom_range(1, 5);
		end else begin
			rq.op = OP_UNUSED;
		end
		return rq;
	endfunction

	task automatic issue_request(input request_t rq, input bit typed, input result_t typed_res);
		int      gap;
		result_t predicted;
		gap = burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= rq.op;
		start_id <= rq.start_id;
		end_id <= rq.end_id;
		lookup_id <= rq.lookup_id;
		value_in <= rq.value_in;
		do @(posedge clk); while (in_stall);
		predicted = id_table_apply(rq);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	// Let the block go idle before touching the base register
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_base(input logic [31:0] b);
		cfg_valid <= 1'b1;
		cfg_data <= b;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_model = b;
	endtask

	initial begin : stimulus
		logic [31:0] bases[$];
		int          p;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_ALLOC;
		start_id = '0;
		end_id = '0;
		lookup_id = '0;
		value_in = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		bases = '{32'd0, 32'd1000, 32'h7FFF_FF80, 32'hFFFF_FFFF, 32'hFFFF_FF00,
			32'h8000_0000, $urandom_range(1, 32'h7FFF_0000), 32'd0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			issue_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].res);
		for (p = 0; p < bases.size(); p++) begin
			drain_pipeline();
			write_base(bases[p]);
			burst = (p % 3 == 2);
			// Park the receiver long enough to back the block up into its input
			if (p == 1)
				long_hold = 1'b1;
			repeat (PHASE_ITEMS)
				issue_request(random_request(), 1'b0, '0);
		end
		drain_pipeline();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : result_sink
		int      hold;
		result_t got;
		result_t want;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				hold = 300;
				long_hold = 1'b0;
			end else begin
				hold = burst ? 0 : $urandom_range(0, 10);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			got.status = status;
			got.granted_id = granted_id;
			got.value_out = value_out;
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d granted_id %h value_out %h",
					got.status, got.granted_id, got.value_out);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					mismatch_count++;
				end
				if (got.granted_id !== want.granted_id) begin
					$error("granted_id: expected %h, got %h", want.granted_id, got.granted_id);
					mismatch_count++;
				end
				if (got.value_out !== want.value_out) begin
					$error("value_out: expected %h, got %h", want.value_out, got.value_out);
					mismatch_count++;
				end
			end
		end
	end

	// Abort when no transaction moves on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
